// ===== hw/rtl/lswp_pkg.sv =====
// Shared constants and types for the latency statistics monitor.
`timescale 1ns / 1ps
`default_nettype none

package lswp_pkg;

    localparam int NUM_OPS_DEF     = 16;
    localparam int WINDOW_DEF      = 1024;
    localparam int MIN_SAMPLES_DEF = 100;

    localparam int DATA_W = 32;
    localparam int SUM_W  = 64;

    localparam int PCT_NUM = 99;
    localparam int PCT_DEN = 100;

    // floor(fill*99/100) as (fill * PCT_MUL) >> PCT_SHIFT, exact for fill up to 4096
    localparam int PCT_MUL   = 66437811;
    localparam int PCT_SHIFT = 26;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_END   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lswp_div.sv =====
// Iterative 64 by 32 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module lswp_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lswp_pkg::div_req_t                  req,
    output logic                                     done,
    output logic [lswp_pkg::SUM_W-1:0]               quotient
);

    logic [lswp_pkg::SUM_W-1:0]  quo_reg;
    logic [lswp_pkg::DATA_W-1:0] rem_reg;
    logic [lswp_pkg::DATA_W-1:0] dsr_reg;
    logic [6:0]                  cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [lswp_pkg::DATA_W:0]   trial;
    logic [lswp_pkg::DATA_W:0]   diff;
    logic                        ge;

    assign trial = {rem_reg, quo_reg[lswp_pkg::SUM_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(lswp_pkg::SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[lswp_pkg::SUM_W-2:0], ge};
            rem_reg <= ge ? diff[lswp_pkg::DATA_W-1:0] : trial[lswp_pkg::DATA_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lswp_select.sv =====
// Bitwise radix select: k-th smallest of the window, one bit per pass over memory.
`timescale 1ns / 1ps
`default_nettype none

module lswp_select #(
    parameter int WINDOW = lswp_pkg::WINDOW_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic [$clog2(WINDOW+1)-1:0]           fill,
    input  wire logic [$clog2(WINDOW+1)-1:0]           rank,
    output logic                                       rd_en,
    output logic [$clog2(WINDOW)-1:0]                  rd_idx,
    input  wire logic [lswp_pkg::DATA_W-1:0]           rd_data,
    output logic                                       done,
    output logic [lswp_pkg::DATA_W-1:0]                result
);

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int IDX_W  = $clog2(WINDOW);

    typedef enum logic [1:0] {SL_IDLE, SL_SCAN, SL_DECIDE} sel_state_t;

    sel_state_t                  state_reg;
    logic [FILL_W-1:0]           fill_reg;
    logic [FILL_W-1:0]           k_reg;
    logic [FILL_W-1:0]           issue_reg;
    logic [FILL_W-1:0]           cnt_reg;
    logic                        vld_reg;
    logic                        done_reg;
    logic [lswp_pkg::DATA_W-1:0] prefix_reg;
    logic [lswp_pkg::DATA_W-1:0] known_reg;
    logic [lswp_pkg::DATA_W-1:0] bit_reg;

    logic match;

    assign rd_en  = (state_reg == SL_SCAN) && (issue_reg < fill_reg);
    assign rd_idx = issue_reg[IDX_W-1:0];
    // sample agrees with the decided upper bits and has a zero at the current bit
    assign match  = (((rd_data ^ prefix_reg) & known_reg) == '0) && ((rd_data & bit_reg) == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SL_IDLE;
            fill_reg   <= '0;
            k_reg      <= '0;
            issue_reg  <= '0;
            cnt_reg    <= '0;
            vld_reg    <= 1'b0;
            done_reg   <= 1'b0;
            prefix_reg <= '0;
            known_reg  <= '0;
            bit_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            vld_reg  <= rd_en;
            case (state_reg)
                SL_IDLE:
                begin
                    if (start)
                    begin
                        fill_reg   <= fill;
                        k_reg      <= rank;
                        issue_reg  <= '0;
                        cnt_reg    <= '0;
                        prefix_reg <= '0;
                        known_reg  <= '0;
                        bit_reg    <= {1'b1, {(lswp_pkg::DATA_W-1){1'b0}}};
                        state_reg  <= SL_SCAN;
                    end
                end
                SL_SCAN:
                begin
                    if (rd_en)
                        issue_reg <= issue_reg + 1'b1;
                    if (vld_reg && match)
                        cnt_reg <= cnt_reg + 1'b1;
                    if (!rd_en && !vld_reg)
                        state_reg <= SL_DECIDE;
                end
                SL_DECIDE:
                begin
                    if (k_reg >= cnt_reg)
                    begin
                        prefix_reg <= prefix_reg | bit_reg;
                        k_reg      <= k_reg - cnt_reg;
                    end
                    known_reg <= known_reg | bit_reg;
                    issue_reg <= '0;
                    cnt_reg   <= '0;
                    if (bit_reg[0])
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= SL_IDLE;
                    end
                    else
                    begin
                        bit_reg   <= bit_reg >> 1;
                        state_reg <= SL_SCAN;
                    end
                end
                default:
                begin
                    state_reg <= SL_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = prefix_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/latency_stats_window_percentile.sv =====
// Top level: per-slot latency statistics with windowed 99th percentile.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, req_type, op_id,      | item in
//          | timestamp                                 |
//  out     | out_valid, out_stall, status, duration,   | result out
//          | sample_total, min/max/avg/p99_latency     |
//
// Start, clear and error items are handled in the decode state. A recorded end
// item raises its result when the 64-bit divide for the average is done; with
// the percentile (fill >= MIN_SAMPLES) the divide starts after 32 passes of the
// radix select over the window memory's single read port. Reset clears the slot
// flags, counts, extremes, sums and window pointers at once; no clearing pass.
// in_stall stays high while an item is in work or a result waits.
`timescale 1ns / 1ps
`default_nettype none

module latency_stats_window_percentile #(
    parameter int NUM_OPS     = lswp_pkg::NUM_OPS_DEF,
    parameter int WINDOW      = lswp_pkg::WINDOW_DEF,
    parameter int MIN_SAMPLES = lswp_pkg::MIN_SAMPLES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [3:0]  op_id,
    input  wire logic [31:0] timestamp,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             status,
    output logic [31:0]      duration,
    output logic [31:0]      sample_total,
    output logic [31:0]      min_latency,
    output logic [31:0]      max_latency,
    output logic [31:0]      avg_latency,
    output logic [31:0]      p99_latency
);

    localparam int DW     = lswp_pkg::DATA_W;
    localparam int SW     = lswp_pkg::SUM_W;
    localparam int SLOT_W = (NUM_OPS > 1) ? $clog2(NUM_OPS) : 1;
    localparam int HEAD_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int DEPTH  = NUM_OPS * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RANK_W = FILL_W + lswp_pkg::PCT_SHIFT;

    typedef enum logic [2:0] {S_IDLE, S_DECODE, S_SEL, S_AVG_WAIT} state_t;

    state_t            state_reg;
    logic [1:0]        req_reg;
    logic [3:0]        op_reg;
    logic [DW-1:0]     ts_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [DW-1:0]     dur_reg;
    logic [DW-1:0]     p99_reg;
    lswp_pkg::div_req_t div_req_reg;
    logic              sel_start_reg;

    logic              out_valid_reg;
    logic              status_reg;
    logic [DW-1:0]     duration_reg;
    logic [DW-1:0]     total_reg;
    logic [DW-1:0]     min_reg;
    logic [DW-1:0]     max_reg;
    logic [DW-1:0]     avg_reg;
    logic [DW-1:0]     p99_out_reg;

    // per-slot state
    logic [DW-1:0]     start_time  [NUM_OPS];
    logic              active_flag [NUM_OPS];
    logic [DW-1:0]     count_store [NUM_OPS];
    logic [DW-1:0]     min_store   [NUM_OPS];
    logic [DW-1:0]     max_store   [NUM_OPS];
    logic [SW-1:0]     sum_store   [NUM_OPS];
    logic [HEAD_W-1:0] window_head [NUM_OPS];
    logic [FILL_W-1:0] window_fill [NUM_OPS];

    logic [DW-1:0]     window_mem [DEPTH];
    logic [DW-1:0]     rd_data_reg;

    logic              op_ok;
    logic [SLOT_W-1:0] slot;
    logic              rec;
    logic [DW-1:0]     dur;
    logic              first;
    logic [DW-1:0]     min_new;
    logic [DW-1:0]     max_new;
    logic [DW-1:0]     cnt_new;
    logic [SW:0]       sum_ext;
    logic [SW-1:0]     sum_new;
    logic [HEAD_W-1:0] head_new;
    logic [FILL_W-1:0] fill_new;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] wr_addr;
    logic              use_pct;
    logic [RANK_W-1:0] rank_prod;

    logic              div_done;
    logic [SW-1:0]     div_quo;
    logic              sel_rd_en;
    logic [HEAD_W-1:0] sel_rd_idx;
    logic              sel_done;
    logic [DW-1:0]     sel_result;

    assign op_ok    = 32'(op_reg) < 32'(NUM_OPS);
    assign slot     = SLOT_W'(op_reg);
    assign rec      = (req_reg == lswp_pkg::REQ_END) && op_ok && active_flag[slot];
    assign dur      = ts_reg - start_time[slot];
    assign first    = count_store[slot] == '0;
    assign min_new  = (first || dur < min_store[slot]) ? dur : min_store[slot];
    assign max_new  = (first || dur > max_store[slot]) ? dur : max_store[slot];
    assign cnt_new  = (&count_store[slot]) ? count_store[slot] : count_store[slot] + 1'b1;
    assign sum_ext  = {1'b0, sum_store[slot]} + {{(SW-DW+1){1'b0}}, dur};
    assign sum_new  = sum_ext[SW] ? {SW{1'b1}} : sum_ext[SW-1:0];
    assign head_new = (window_head[slot] == HEAD_W'(WINDOW - 1)) ? '0
                                                                 : window_head[slot] + 1'b1;
    assign fill_new = (32'(window_fill[slot]) < 32'(WINDOW)) ? window_fill[slot] + 1'b1
                                                             : window_fill[slot];
    assign base     = ADDR_W'(slot) * ADDR_W'(WINDOW);
    assign wr_addr  = base + ADDR_W'(window_head[slot]);
    assign use_pct  = 32'(fill_new) >= 32'(MIN_SAMPLES);
    // rank of the percentile in the sorted window, by reciprocal multiplication
    assign rank_prod = RANK_W'(fill_reg) * RANK_W'(lswp_pkg::PCT_MUL);

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;

    // slot table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_OPS; i++)
            begin
                active_flag[i] <= 1'b0;
                count_store[i] <= '0;
                min_store[i]   <= '0;
                max_store[i]   <= '0;
                sum_store[i]   <= '0;
                window_head[i] <= '0;
                window_fill[i] <= '0;
            end
        end
        else if (state_reg == S_DECODE)
        begin
            if (req_reg == lswp_pkg::REQ_CLEAR)
            begin
                for (int i = 0; i < NUM_OPS; i++)
                begin
                    active_flag[i] <= 1'b0;
                    count_store[i] <= '0;
                    min_store[i]   <= '0;
                    max_store[i]   <= '0;
                    sum_store[i]   <= '0;
                    window_head[i] <= '0;
                    window_fill[i] <= '0;
                end
            end
            else if (req_reg == lswp_pkg::REQ_START && op_ok)
            begin
                active_flag[slot] <= 1'b1;
            end
            else if (rec)
            begin
                active_flag[slot] <= 1'b0;
                count_store[slot] <= cnt_new;
                min_store[slot]   <= min_new;
                max_store[slot]   <= max_new;
                sum_store[slot]   <= sum_new;
                window_head[slot] <= head_new;
                window_fill[slot] <= fill_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DECODE && req_reg == lswp_pkg::REQ_START && op_ok)
            start_time[slot] <= ts_reg;
    end

    // window sample memory
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DECODE && rec)
            window_mem[wr_addr] <= dur;
    end

    always_ff @(posedge clk)
    begin
        if (sel_rd_en)
            rd_data_reg <= window_mem[base_reg + ADDR_W'(sel_rd_idx)];
    end

    lswp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    lswp_select #(
        .WINDOW (WINDOW)
    ) u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sel_start_reg),
        .fill    (fill_reg),
        .rank    (rank_prod[lswp_pkg::PCT_SHIFT +: FILL_W]),
        .rd_en   (sel_rd_en),
        .rd_idx  (sel_rd_idx),
        .rd_data (rd_data_reg),
        .done    (sel_done),
        .result  (sel_result)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            op_reg        <= '0;
            ts_reg        <= '0;
            slot_reg      <= '0;
            base_reg      <= '0;
            fill_reg      <= '0;
            dur_reg       <= '0;
            p99_reg       <= '0;
            div_req_reg   <= '0;
            sel_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= 1'b0;
            duration_reg  <= '0;
            total_reg     <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            avg_reg       <= '0;
            p99_out_reg   <= '0;
        end
        else
        begin
            div_req_reg.start <= 1'b0;
            sel_start_reg     <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        req_reg   <= req_type;
                        op_reg    <= op_id;
                        ts_reg    <= timestamp;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    state_reg <= S_IDLE;
                    if (req_reg == lswp_pkg::REQ_END)
                    begin
                        if (!rec)
                        begin
                            out_valid_reg <= 1'b1;
                            status_reg    <= lswp_pkg::STATUS_ERR;
                            duration_reg  <= '0;
                            total_reg     <= '0;
                            min_reg       <= '0;
                            max_reg       <= '0;
                            avg_reg       <= '0;
                            p99_out_reg   <= '0;
                        end
                        else
                        begin
                            slot_reg <= slot;
                            base_reg <= base;
                            fill_reg <= fill_new;
                            dur_reg  <= dur;
                            if (use_pct)
                            begin
                                sel_start_reg <= 1'b1;
                                state_reg     <= S_SEL;
                            end
                            else
                            begin
                                p99_reg              <= max_new;
                                div_req_reg.start    <= 1'b1;
                                div_req_reg.dividend <= sum_new;
                                div_req_reg.divisor  <= cnt_new;
                                state_reg            <= S_AVG_WAIT;
                            end
                        end
                    end
                end
                S_SEL:
                begin
                    if (sel_done)
                    begin
                        p99_reg              <= sel_result;
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.dividend <= sum_store[slot_reg];
                        div_req_reg.divisor  <= count_store[slot_reg];
                        state_reg            <= S_AVG_WAIT;
                    end
                end
                S_AVG_WAIT:
                begin
                    if (div_done)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= lswp_pkg::STATUS_OK;
                        duration_reg  <= dur_reg;
                        total_reg     <= count_store[slot_reg];
                        min_reg       <= min_store[slot_reg];
                        max_reg       <= max_store[slot_reg];
                        avg_reg       <= (|div_quo[SW-1:DW]) ? {DW{1'b1}} : div_quo[DW-1:0];
                        p99_out_reg   <= p99_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign duration     = duration_reg;
    assign sample_total = total_reg;
    assign min_latency  = min_reg;
    assign max_latency  = max_reg;
    assign avg_latency  = avg_reg;
    assign p99_latency  = p99_out_reg;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for the latency statistics monitor: directed and random items, checked per result.
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT_CYCLES = 5000000;
    localparam int EXP_DEPTH    = 16;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic        status;
        logic [31:0] duration;
        logic [31:0] sample_total;
        logic [31:0] min_latency;
        logic [31:0] max_latency;
        logic [31:0] avg_latency;
        logic [31:0] p99_latency;
    } stats_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [3:0]  op_id;
    logic [31:0] timestamp;
    logic        out_valid;
    logic        out_stall;
    logic        status;
    logic [31:0] duration;
    logic [31:0] sample_total;
    logic [31:0] min_latency;
    logic [31:0] max_latency;
    logic [31:0] avg_latency;
    logic [31:0] p99_latency;

    // predictor state
    logic [31:0] slot_start  [lswp_pkg::NUM_OPS_DEF];
    logic        slot_active [lswp_pkg::NUM_OPS_DEF];
    logic [31:0] slot_count  [lswp_pkg::NUM_OPS_DEF];
    logic [31:0] slot_min    [lswp_pkg::NUM_OPS_DEF];
    logic [31:0] slot_max    [lswp_pkg::NUM_OPS_DEF];
    logic [63:0] slot_sum    [lswp_pkg::NUM_OPS_DEF];
    logic [31:0] slot_win    [lswp_pkg::NUM_OPS_DEF][lswp_pkg::WINDOW_DEF];
    int          slot_head   [lswp_pkg::NUM_OPS_DEF];
    int          slot_fill   [lswp_pkg::NUM_OPS_DEF];

    // expected results in order
    stats_t      exp_fifo [EXP_DEPTH];
    int          exp_wr;
    int          exp_rd;
    int          errors;
    int          cycles;
    bit          quiet;
    int          stall_left;

    latency_stats_window_percentile u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .op_id(op_id), .timestamp(timestamp),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .duration(duration), .sample_total(sample_total),
        .min_latency(min_latency), .max_latency(max_latency),
        .avg_latency(avg_latency), .p99_latency(p99_latency)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic void clear_slots();
        for (int i = 0; i < lswp_pkg::NUM_OPS_DEF; i++)
        begin
            slot_active[i] = 1'b0;
            slot_count[i]  = '0;
            slot_min[i]    = '0;
            slot_max[i]    = '0;
            slot_sum[i]    = '0;
            slot_head[i]   = 0;
            slot_fill[i]   = 0;
        end
    endfunction

    function automatic void exp_put(stats_t s);
        exp_fifo[exp_wr % EXP_DEPTH] = s;
        exp_wr++;
    endfunction

    function automatic void predict_stats(logic [1:0] req, logic [3:0] op, logic [31:0] ts);
        stats_t      r;
        logic [31:0] dur;
        logic [63:0] q;
        logic [31:0] srt [lswp_pkg::WINDOW_DEF];
        logic [31:0] key;
        int          n;
        int          j;
        if (req == lswp_pkg::REQ_CLEAR)
            clear_slots();
        else if (req == lswp_pkg::REQ_START)
        begin
            slot_start[op]  = ts;
            slot_active[op] = 1'b1;
        end
        else if (req == lswp_pkg::REQ_END)
        begin
            if (!slot_active[op])
            begin
                r = '{lswp_pkg::STATUS_ERR, 0, 0, 0, 0, 0, 0};
            end
            else
            begin
                dur = ts - slot_start[op];
                slot_active[op] = 1'b0;
                if (slot_count[op] == 0 || dur < slot_min[op])
                    slot_min[op] = dur;
                if (slot_count[op] == 0 || dur > slot_max[op])
                    slot_max[op] = dur;
                if (slot_count[op] != 32'hFFFF_FFFF)
                    slot_count[op]++;
                if (slot_sum[op] > 64'hFFFF_FFFF_FFFF_FFFF - {32'd0, dur})
                    slot_sum[op] = 64'hFFFF_FFFF_FFFF_FFFF;
                else
                    slot_sum[op] += {32'd0, dur};
                slot_win[op][slot_head[op]] = dur;
                slot_head[op] = (slot_head[op] + 1 >= lswp_pkg::WINDOW_DEF) ? 0
                                                                            : slot_head[op] + 1;
                if (slot_fill[op] < lswp_pkg::WINDOW_DEF)
                    slot_fill[op]++;
                r.status       = lswp_pkg::STATUS_OK;
                r.duration     = dur;
                r.sample_total = slot_count[op];
                r.min_latency  = slot_min[op];
                r.max_latency  = slot_max[op];
                if (slot_fill[op] >= lswp_pkg::MIN_SAMPLES_DEF)
                begin
                    n = slot_fill[op];
                    // insertion sort of the window
                    for (int i = 0; i < n; i++)
                    begin
                        key = slot_win[op][i];
                        j = i;
                        while (j > 0 && srt[j-1] > key)
                        begin
                            srt[j] = srt[j-1];
                            j--;
                        end
                        srt[j] = key;
                    end
                    r.p99_latency = srt[(n * lswp_pkg::PCT_NUM) / lswp_pkg::PCT_DEN];
                end
                else
                    r.p99_latency = slot_max[op];
                q = slot_sum[op] / {32'd0, slot_count[op]};
                r.avg_latency = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            end
            exp_put(r);
        end
    endfunction

    function automatic int pick_gap();
        if (quiet)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 80);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // called at a rising edge; leaves at the edge where the item was accepted
    task automatic send_item(logic [1:0] req, logic [3:0] op, logic [31:0] ts);
        int  gap;
        logic st;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        op_id     <= op;
        timestamp <= ts;
        do
        begin
            @(negedge clk);
            st = in_stall;
            @(posedge clk);
        end
        while (st);
        predict_stats(req, op, ts);
    endtask

    task automatic timed_pair(logic [3:0] op, logic [31:0] ts0, logic [31:0] dur);
        send_item(lswp_pkg::REQ_START, op, ts0);
        send_item(lswp_pkg::REQ_END, op, ts0 + dur);
    endtask

    function automatic logic [31:0] rand_dur();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15);
            1: return $urandom_range(0, 5000);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // receiver: sample at the falling edge, stall changes at the rising edge
    initial
    begin
        stats_t e;
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (exp_wr == exp_rd)
                begin
                    $display("%0t: unexpected result status=%0d duration=%0d",
                             $time, status, duration);
                    errors++;
                end
                else
                begin
                    e = exp_fifo[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (status !== e.status)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, e.status, status);
                        errors++;
                    end
                    if (duration !== e.duration)
                    begin
                        $display("%0t: duration exp %0d got %0d", $time, e.duration, duration);
                        errors++;
                    end
                    if (sample_total !== e.sample_total)
                    begin
                        $display("%0t: sample_total exp %0d got %0d", $time,
                                 e.sample_total, sample_total);
                        errors++;
                    end
                    if (min_latency !== e.min_latency)
                    begin
                        $display("%0t: min exp %0d got %0d", $time, e.min_latency, min_latency);
                        errors++;
                    end
                    if (max_latency !== e.max_latency)
                    begin
                        $display("%0t: max exp %0d got %0d", $time, e.max_latency, max_latency);
                        errors++;
                    end
                    if (avg_latency !== e.avg_latency)
                    begin
                        $display("%0t: avg exp %0d got %0d", $time, e.avg_latency, avg_latency);
                        errors++;
                    end
                    if (p99_latency !== e.p99_latency)
                    begin
                        $display("%0t: p99 exp %0d got %0d", $time, e.p99_latency, p99_latency);
                        errors++;
                    end
                end
            end
            @(posedge clk);
            if (quiet)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                stall_left = $urandom_range(20, 100);
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    task automatic test_errors();
        send_item(lswp_pkg::REQ_END, 4'd0, 32'd0);
        send_item(lswp_pkg::REQ_END, 4'd15, 32'hFFFF_FFFF);
        send_item(REQ_UNUSED, 4'd3, 32'h1234_5678);
        send_item(lswp_pkg::REQ_END, 4'd3, 32'h1234_5678);
        // clear cancels an open measurement
        send_item(lswp_pkg::REQ_START, 4'd7, 32'd100);
        send_item(lswp_pkg::REQ_CLEAR, 4'd0, 32'd0);
        send_item(lswp_pkg::REQ_END, 4'd7, 32'd200);
    endtask

    task automatic test_extremes();
        timed_pair(4'd1, 32'hFFFF_FFFF, 32'd1);        // wraps through zero
        timed_pair(4'd1, 32'd0, 32'hFFFF_FFFF);
        timed_pair(4'd1, 32'h8000_0000, 32'd0);
        send_item(lswp_pkg::REQ_START, 4'd2, 32'd10);
        send_item(lswp_pkg::REQ_START, 4'd2, 32'd50);  // restart overwrites timestamp
        send_item(lswp_pkg::REQ_END, 4'd2, 32'd60);
        send_item(lswp_pkg::REQ_END, 4'd2, 32'd70);    // already closed
        timed_pair(4'd15, 32'hAAAA_AAAA, 32'h5555_5555);
        timed_pair(4'd0, 32'h5555_5555, 32'd3);
    endtask

    task automatic test_percentile();
        // fill one slot past the sample minimum so the window is sorted
        for (int i = 0; i < 102; i++)
            timed_pair(4'd9, $urandom, rand_dur());
    endtask

    task automatic test_random();
        logic [3:0] op;
        for (int i = 0; i < 44; )
        begin
            quiet = ($urandom_range(0, 9) == 0);
            op = $urandom;
            case ($urandom_range(0, 19))
                0: begin send_item(lswp_pkg::REQ_CLEAR, op, $urandom); i++; end
                1: begin send_item(REQ_UNUSED, op, $urandom); i++; end
                2, 3: begin send_item(lswp_pkg::REQ_END, op, $urandom); i++; end
                4: begin send_item(lswp_pkg::REQ_START, op, $urandom); i++; end
                default: begin timed_pair(op, $urandom, rand_dur()); i += 2; end
            endcase
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        errors    = 0;
        exp_wr    = 0;
        exp_rd    = 0;
        quiet     = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = lswp_pkg::REQ_START;
        op_id     = '0;
        timestamp = '0;
        clear_slots();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_errors();
        test_extremes();
        test_percentile();
        test_random();
        in_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && exp_wr == exp_rd)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== latency_stats_window_percentile.f =====
hw/rtl/lswp_pkg.sv
hw/rtl/lswp_div.sv
hw/rtl/lswp_select.sv
hw/rtl/latency_stats_window_percentile.sv
bench/tb_top.sv
